/* rtl/core/lcns_pkg.sv */
// shared types and constants for the life cell next-state unit
`timescale 1ns / 1ps
`default_nettype none

package lcns_pkg;

  // coordinate fields are 6 bits, so storage always spans 64 rows of 64 cells
  localparam int unsigned BOARD_SIZE  = 64;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned BOARD_DEPTH = 2 ** COORD_W;
  localparam int unsigned ROW_W       = BOARD_DEPTH;
  localparam int unsigned COUNT_W     = 4;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_EVAL  = 1'b1
  } kind_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_value;
  } in_item_t;

  typedef struct packed {
    logic               next_alive;
    logic               current_alive;
    logic [COUNT_W-1:0] neighbor_count;
    logic               point_valid;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/life_cell_next_state_unit.sv */
// top level: cell board storage and b3/s23 next-state evaluation
//
// Usage: an input transaction (in_valid high, in_stall low) either writes one
// cell of the 64 x 64 board or asks for the next state of one cell. Each input
// transaction gives exactly one result transaction on the out_ channel, in
// order. A coordinate off the board changes nothing and returns point_valid 0.
// Pipeline: board rows are read into the read stage when a transaction is
// accepted; count and rule then set the output register when it advances.
// Throughput: one transaction per cycle unless in_stall is high; the three
// row banks are each read once per transaction, so only the handshake limits it.
// Reset: rst_n low clears the pipeline and marks every board row as dead at
// once through per-row valid bits; no clearing pass is needed.
// Stall: while out_stall holds a result, one more transaction is still
// accepted into the read stage; after that in_stall rises until the result
// is taken. A stalled result does not change.
`timescale 1ns / 1ps
`default_nettype none

module life_cell_next_state_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  lcns_pkg::in_item_t in_item,
  output logic               out_valid,
  input  wire                out_stall,
  output lcns_pkg::out_item_t out_item
);
  import lcns_pkg::*;

  // three copies of the board, one per window row, all written alike
  logic [ROW_W-1:0] bank_up   [BOARD_DEPTH];
  logic [ROW_W-1:0] bank_mid  [BOARD_DEPTH];
  logic [ROW_W-1:0] bank_dn   [BOARD_DEPTH];
  logic [BOARD_DEPTH-1:0] row_vld_r;

  logic             in_accept;
  logic             s1_advance;
  logic             on_board;
  logic             do_write;
  logic [COORD_W-1:0] addr_up;
  logic [COORD_W-1:0] addr_dn;
  logic             up_ok;
  logic             dn_ok;
  logic [ROW_W-1:0] col_hot;
  logic [ROW_W-1:0] wr_mask;
  logic [ROW_W-1:0] wr_data;

  // read stage
  logic             s1_valid_r;
  logic             s1_kind_r;
  logic             s1_point_r;
  logic [COORD_W-1:0] s1_col_r;
  logic             s1_value_r;
  logic [ROW_W-1:0] rd_up_r;
  logic [ROW_W-1:0] rd_mid_r;
  logic [ROW_W-1:0] rd_dn_r;
  logic             vld_up_r;
  logic             vld_mid_r;
  logic             vld_dn_r;

  // evaluate stage
  logic [ROW_W+1:0] ext_up;
  logic [ROW_W+1:0] ext_mid;
  logic [ROW_W+1:0] ext_dn;
  logic [2:0]       win_up;
  logic [2:0]       win_mid;
  logic [2:0]       win_dn;
  logic [7:0]       nbr_bits;
  logic [COUNT_W-1:0] nbr_count;
  logic             cur_alive;
  logic             nxt_alive;
  out_item_t        result_nxt;
  out_item_t        out_item_r;
  logic             out_valid_r;

  assign s1_advance = !out_valid_r || !out_stall;
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  assign on_board = ({1'b0, in_item.row} < (COORD_W+1)'(BOARD_SIZE)) &&
                    ({1'b0, in_item.col} < (COORD_W+1)'(BOARD_SIZE));
  assign do_write = in_accept && on_board && (in_item.kind == KIND_WRITE);

  assign addr_up = in_item.row - COORD_W'(1);
  assign addr_dn = in_item.row + COORD_W'(1);
  assign up_ok   = in_item.row != '0;
  assign dn_ok   = in_item.row != '1;

  assign col_hot = ROW_W'(1) << in_item.col;

  // a row never written holds garbage, so the first write fills the whole row
  always_comb begin
    if (row_vld_r[in_item.row]) begin
      wr_mask = col_hot;
      wr_data = {ROW_W{in_item.cell_value}};
    end else begin
      wr_mask = '1;
      wr_data = in_item.cell_value ? col_hot : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      for (int i = 0; i < ROW_W; i++) begin
        if (wr_mask[i]) begin
          bank_up[in_item.row][i]  <= wr_data[i];
          bank_mid[in_item.row][i] <= wr_data[i];
          bank_dn[in_item.row][i]  <= wr_data[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_up_r  <= bank_up[addr_up];
      rd_mid_r <= bank_mid[in_item.row];
      rd_dn_r  <= bank_dn[addr_dn];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (do_write) begin
      row_vld_r[in_item.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= in_item.kind;
      s1_point_r <= on_board;
      s1_col_r   <= in_item.col;
      s1_value_r <= in_item.cell_value;
      vld_up_r   <= up_ok && row_vld_r[addr_up];
      vld_mid_r  <= row_vld_r[in_item.row];
      vld_dn_r   <= dn_ok && row_vld_r[addr_dn];
    end
  end

  // zero pad both ends so the edge columns see dead neighbors
  assign ext_up  = {1'b0, rd_up_r  & {ROW_W{vld_up_r}},  1'b0};
  assign ext_mid = {1'b0, rd_mid_r & {ROW_W{vld_mid_r}}, 1'b0};
  assign ext_dn  = {1'b0, rd_dn_r  & {ROW_W{vld_dn_r}},  1'b0};

  assign win_up  = ext_up[s1_col_r +: 3];
  assign win_mid = ext_mid[s1_col_r +: 3];
  assign win_dn  = ext_dn[s1_col_r +: 3];

  assign nbr_bits  = {win_up, win_mid[2], win_mid[0], win_dn};
  assign cur_alive = win_mid[1];

  always_comb begin
    nbr_count = '0;
    for (int i = 0; i < 8; i++) begin
      nbr_count = nbr_count + COUNT_W'(nbr_bits[i]);
    end
  end

  assign nxt_alive = (nbr_count == BIRTH_COUNT) ||
                     (cur_alive && (nbr_count == SURVIVE_COUNT));

  always_comb begin
    result_nxt = '0;
    if (s1_point_r) begin
      result_nxt.point_valid = 1'b1;
      if (s1_kind_r == KIND_WRITE) begin
        result_nxt.current_alive = s1_value_r;
      end else begin
        result_nxt.current_alive  = cur_alive;
        result_nxt.neighbor_count = nbr_count;
        result_nxt.next_alive     = nxt_alive;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid_r) begin
      out_item_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* rtl/core/lcns_checker.sv */
// port-level checker for the life cell next-state unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lcns_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input lcns_pkg::in_item_t  in_item,
  input wire                 out_valid,
  input wire                 out_stall,
  input lcns_pkg::out_item_t out_item
);
  import lcns_pkg::*;

  // a stalled result transaction stays and keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // off-board results carry nothing else
  a_off_board_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.point_valid |->
      !out_item.next_alive && !out_item.current_alive && out_item.neighbor_count == '0)
    else $error("off-board result has nonzero fields");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.neighbor_count <= COUNT_W'(8))
    else $error("neighbor count above eight");

  // birth on three, survival on two or three
  a_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.next_alive |->
      out_item.neighbor_count == BIRTH_COUNT ||
      (out_item.current_alive && out_item.neighbor_count == SURVIVE_COUNT))
    else $error("next state breaks b3/s23");

  // with the result side stalled, the unit holds at most two transactions
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && in_valid && !in_stall |=> in_stall || !out_stall)
    else $error("input taken with both stages full");

endmodule

bind life_cell_next_state_unit lcns_checker u_lcns_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
